@@ rtl/core/ackc_pkg.sv @@
// shared types and constants of the cook controller
package ackc_pkg;

	localparam logic [4:0] BTN_NONE  = 5'd20;
	localparam logic [4:0] BTN_TIME  = 5'd13;
	localparam logic [4:0] BTN_STOP  = 5'd15;
	localparam logic [4:0] BTN_POWER = 5'd16;
	localparam logic [4:0] BTN_CLOCK = 5'd18;
	localparam logic [4:0] BTN_START = 5'd19;

	localparam logic [2:0] CUE_NONE   = 3'd0;
	localparam logic [2:0] CUE_BUTTON = 3'd1;
	localparam logic [2:0] CUE_START  = 3'd2;
	localparam logic [2:0] CUE_STOP   = 3'd3;
	localparam logic [2:0] CUE_DONE   = 3'd4;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ROW  = 2'd1;
	localparam logic [1:0] OP_HOST = 2'd2;

	localparam logic [2:0] HC_RAW   = 3'd0;
	localparam logic [2:0] HC_TIME  = 3'd1;
	localparam logic [2:0] HC_POWER = 3'd2;
	localparam logic [2:0] HC_START = 3'd3;
	localparam logic [2:0] HC_STOP  = 3'd4;
	localparam logic [2:0] HC_PAUSE = 3'd5;
	localparam logic [2:0] HC_CLOCK = 3'd6;
	localparam logic [2:0] HC_KEY   = 3'd7;

	localparam logic [1:0] REG_SECOND   = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_VOICE    = 2'd2;

	localparam logic [12:0] MAX_SECS  = 13'd5999;
	localparam logic [16:0] VOICE_SAT = 17'h1FFFF;
	localparam int unsigned NSLOT     = 17;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  scan_row;
		logic [5:0]  column_bits;
		logic        door_closed;
		logic [2:0]  host_command;
		logic [12:0] host_value;
		logic        from_voice;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  panel_button;
		logic        last_result;
		logic [2:0]  sound_cue;
		logic        cooking;
		logic        is_paused;
		logic        door_is_open;
		logic [12:0] time_left;
		logic [3:0]  power_level;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        door_closed;
		logic        cols_any;
		logic [4:0]  key;
		logic [2:0]  host_command;
		logic [12:0] host_value;
		logic        from_voice;
	} work_t;

	typedef struct packed {
		logic        cooking;
		logic        is_paused;
		logic        door_is_open;
		logic [12:0] time_left;
		logic [3:0]  power_level;
	} status_t;

	typedef struct packed {
		logic        a_en;
		logic [4:0]  a_btn;
		logic [2:0]  a_cue;
		logic        time_en;
		logic [12:0] time_secs;
		logic [2:0]  time_cue;
		logic        power_en;
		logic [3:0]  power_val;
		logic [2:0]  power_cue;
		logic        clock_en;
		logic [10:0] clock_val;
		logic        b_en;
		logic [4:0]  b_btn;
		logic [2:0]  b_cue;
		status_t     status;
	} desc_t;

	typedef struct packed {
		logic [15:0] second_ticks;
		logic [15:0] debounce_ticks;
		logic [16:0] voice_window_ticks;
	} cfg_t;

endpackage

@@ rtl/core/appliance_keypad_cook_controller_core.sv @@
// Cook controller top level. Every item yields one to nine results,
// and the output register hands out one result per cycle while
// result_stall is low. An item yields one result for ticks and most row
// samples, up to eight for a quick-cook key. The press sequencer at the
// output hands out the results; items pass a queue, the state stage, a
// digit multiply stage and a slot stage before the output register.
// Registers sit at byte addresses 0, 4 and 8.
module appliance_keypad_cook_controller_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  ackc_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output ackc_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	ackc_pkg::cfg_t  cfg_q;
	ackc_pkg::work_t work, head;
	ackc_pkg::desc_t desc;
	logic            push, pop, q_full, q_valid, desc_valid, desc_take;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.second_ticks       <= 16'd1000;
			cfg_q.debounce_ticks     <= 16'd100;
			cfg_q.voice_window_ticks <= 17'd10000;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				ackc_pkg::REG_SECOND:   cfg_q.second_ticks       <= pwdata[15:0];
				ackc_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks     <= pwdata[15:0];
				ackc_pkg::REG_VOICE:    cfg_q.voice_window_ticks <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ackc_pkg::REG_SECOND:   prdata = {16'd0, cfg_q.second_ticks};
			ackc_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ticks};
			ackc_pkg::REG_VOICE:    prdata = {15'd0, cfg_q.voice_window_ticks};
			default:                prdata = '0;
		endcase
	end

	ackc_front u_front (
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (push),
		.work       (work)
	);

	ackc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (work),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	ackc_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.w          (head),
		.pop        (pop),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_take  (desc_take)
	);

	ackc_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (desc_valid),
		.desc         (desc),
		.desc_take    (desc_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ rtl/core/ackc_front.sv @@
// input handshake and item classification with keypad matrix decode
module ackc_front (
	input  ackc_pkg::in_item_t item,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               q_full,
	output logic               push,
	output ackc_pkg::work_t    work
);

	function automatic logic [4:0] key_at(input logic [2:0] row, input logic [2:0] col);
		logic [4:0] k;
		begin
			case ({row, col})
				6'o05: k = 5'd19;
				6'o11: k = 5'd0;
				6'o12: k = 5'd1;
				6'o13: k = 5'd2;
				6'o14: k = 5'd3;
				6'o21: k = 5'd4;
				6'o22: k = 5'd5;
				6'o23: k = 5'd6;
				6'o24: k = 5'd7;
				6'o30: k = 5'd10;
				6'o31: k = 5'd8;
				6'o32: k = 5'd9;
				6'o33: k = 5'd12;
				6'o34: k = 5'd15;
				6'o41: k = 5'd13;
				6'o42: k = 5'd18;
				6'o43: k = 5'd11;
				6'o44: k = 5'd16;
				6'o50: k = 5'd17;
				6'o52: k = 5'd14;
				default: k = ackc_pkg::BTN_NONE;
			endcase
			return k;
		end
	endfunction

	logic [4:0] key;

	always_comb begin
		key = ackc_pkg::BTN_NONE;
		for (int c = 0; c < 6; c++) begin
			if (key == ackc_pkg::BTN_NONE && item.column_bits[5 - c]) begin
				key = key_at(item.scan_row, 3'(c));
			end
		end
	end

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	always_comb begin
		work.op           = item.operation;
		work.door_closed  = item.door_closed;
		work.cols_any     = |item.column_bits;
		work.key          = key;
		work.host_command = item.host_command;
		work.host_value   = item.host_value;
		work.from_voice   = item.from_voice;
	end

endmodule

@@ rtl/core/ackc_queue.sv @@
// short queue of classified items between front and back
module ackc_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ackc_pkg::work_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output ackc_pkg::work_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ackc_pkg::work_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/ackc_exec.sv @@
// oven state and per-item action descriptor
module ackc_exec (
	input  logic            clk,
	input  logic            arst_n,
	input  ackc_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  ackc_pkg::work_t w,
	output logic            pop,
	output logic            desc_valid,
	output ackc_pkg::desc_t desc,
	input  logic            desc_take
);

	logic        running_q, held_q, door_open_q, start_pend_q;
	logic [12:0] secs_q;
	logic [3:0]  power_q;
	logic [4:0]  last_key_q;
	logic [15:0] release_q, second_q;
	logic [16:0] voice_q;
	logic        desc_valid_s1;
	ackc_pkg::desc_t desc_s1;

	logic        n_running, n_held, n_door, n_sp;
	logic [12:0] n_secs;
	logic [3:0]  n_power;
	logic [4:0]  n_last;
	logic [15:0] n_release, n_second;
	logic [16:0] n_voice;
	logic [16:0] next_cnt;
	logic [13:0] sum;
	logic [12:0] extra;
	logic [12:0] qsecs;
	logic [3:0]  qpow;
	logic        key_go;
	logic [4:0]  kv;
	logic        ok;
	ackc_pkg::desc_t d;

	assign pop        = q_valid && (!desc_valid_s1 || desc_take);
	assign desc_valid = desc_valid_s1;
	assign desc       = desc_s1;

	always_comb begin
		n_running = running_q;
		n_held    = held_q;
		n_door    = door_open_q;
		n_sp      = start_pend_q;
		n_secs    = secs_q;
		n_power   = power_q;
		n_last    = last_key_q;
		n_release = release_q;
		n_second  = second_q;
		n_voice   = voice_q;
		d         = '0;
		key_go    = 1'b0;
		kv        = w.key;
		next_cnt  = {1'b0, second_q} + 17'd1;
		sum       = '0;
		extra     = '0;
		qsecs     = '0;
		qpow      = '0;
		ok        = !w.from_voice || (voice_q < cfg.voice_window_ticks);
		case (w.op)
			ackc_pkg::OP_TICK: begin
				if (release_q != '1) n_release = release_q + 16'd1;
				if (voice_q != ackc_pkg::VOICE_SAT) n_voice = voice_q + 17'd1;
				if (running_q && next_cnt > {1'b0, cfg.second_ticks}) begin
					n_second = '0;
					if (secs_q != '0) n_secs = secs_q - 13'd1;
					if (n_secs == '0) begin
						d.a_en    = 1'b1;
						d.a_btn   = ackc_pkg::BTN_STOP;
						d.a_cue   = ackc_pkg::CUE_DONE;
						n_running = 1'b0;
						n_held    = 1'b0;
						n_sp      = 1'b0;
						n_secs    = '0;
						n_power   = '0;
					end
				end else begin
					n_second = next_cnt[16] ? '1 : next_cnt[15:0];
				end
			end
			ackc_pkg::OP_ROW: begin
				if (!w.door_closed) begin
					if (running_q) begin
						d.a_en    = 1'b1;
						d.a_btn   = ackc_pkg::BTN_STOP;
						d.a_cue   = ackc_pkg::CUE_NONE;
						n_running = 1'b0;
						n_held    = 1'b0;
						n_sp      = 1'b0;
						n_secs    = '0;
						n_power   = '0;
					end
					n_door = 1'b1;
				end else if (door_open_q) begin
					n_door  = 1'b0;
					n_voice = '0;
					if (start_pend_q && secs_q != '0) begin
						d.a_en    = 1'b1;
						d.a_btn   = ackc_pkg::BTN_START;
						d.a_cue   = held_q ? ackc_pkg::CUE_NONE : ackc_pkg::CUE_START;
						n_running = 1'b1;
						n_sp      = 1'b0;
						n_voice   = ackc_pkg::VOICE_SAT;
						n_second  = '0;
						n_held    = 1'b0;
					end
				end
				if (w.cols_any) begin
					if (w.key != ackc_pkg::BTN_NONE && w.key != last_key_q) begin
						key_go = 1'b1;
						n_last = w.key;
					end
					n_release = '0;
				end else if (last_key_q != ackc_pkg::BTN_NONE
						&& release_q > cfg.debounce_ticks) begin
					n_last    = ackc_pkg::BTN_NONE;
					n_release = '0;
				end
			end
			ackc_pkg::OP_HOST: begin
				case (w.host_command)
					ackc_pkg::HC_RAW: begin
						if (w.host_value < 13'd20) begin
							d.b_en  = 1'b1;
							d.b_btn = w.host_value[4:0];
							d.b_cue = ackc_pkg::CUE_NONE;
						end
					end
					ackc_pkg::HC_TIME: begin
						if (ok && w.host_value <= ackc_pkg::MAX_SECS) begin
							n_running   = 1'b0;
							n_secs      = w.host_value;
							d.time_en   = 1'b1;
							d.time_secs = w.host_value;
						end
					end
					ackc_pkg::HC_POWER: begin
						if (ok && w.host_value <= 13'd10) begin
							n_power     = w.host_value[3:0];
							d.power_en  = 1'b1;
							d.power_val = w.host_value[3:0];
						end
					end
					ackc_pkg::HC_START: begin
						if (ok) begin
							if (!door_open_q) begin
								if (secs_q != '0) begin
									d.b_en    = 1'b1;
									d.b_btn   = ackc_pkg::BTN_START;
									d.b_cue   = held_q ? ackc_pkg::CUE_NONE
										: ackc_pkg::CUE_START;
									n_running = 1'b1;
									n_sp      = 1'b0;
									n_voice   = ackc_pkg::VOICE_SAT;
									n_second  = '0;
									n_held    = 1'b0;
								end
							end else begin
								n_sp = 1'b1;
							end
						end
					end
					ackc_pkg::HC_STOP: begin
						if (ok) begin
							d.b_en    = 1'b1;
							d.b_btn   = ackc_pkg::BTN_STOP;
							d.b_cue   = ackc_pkg::CUE_NONE;
							n_running = 1'b0;
							n_held    = 1'b0;
							n_sp      = 1'b0;
							n_secs    = '0;
							n_power   = '0;
						end
					end
					ackc_pkg::HC_PAUSE: begin
						if (running_q) begin
							d.b_en    = 1'b1;
							d.b_btn   = ackc_pkg::BTN_TIME;
							d.b_cue   = ackc_pkg::CUE_NONE;
							n_running = 1'b0;
							n_held    = 1'b1;
						end
					end
					ackc_pkg::HC_CLOCK: begin
						if (w.host_value <= 13'd1259 && w.host_value >= 13'd100) begin
							d.clock_en  = 1'b1;
							d.clock_val = w.host_value[10:0];
						end
					end
					default: begin
						if (w.host_value < 13'd20) begin
							key_go = 1'b1;
							kv     = w.host_value[4:0];
						end
					end
				endcase
			end
			default: ;
		endcase

		if (key_go) begin
			case (kv)
				5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9: begin
					case (kv)
						5'd0:    begin qsecs = 13'd120; qpow = 4'd7;  end
						5'd1:    begin qsecs = 13'd10;  qpow = 4'd10; end
						5'd2:    begin qsecs = 13'd20;  qpow = 4'd10; end
						5'd3:    begin qsecs = 13'd30;  qpow = 4'd10; end
						5'd4:    begin qsecs = 13'd60;  qpow = 4'd10; end
						5'd5:    begin qsecs = 13'd120; qpow = 4'd10; end
						5'd6:    begin qsecs = 13'd10;  qpow = 4'd7;  end
						5'd7:    begin qsecs = 13'd20;  qpow = 4'd7;  end
						5'd8:    begin qsecs = 13'd30;  qpow = 4'd7;  end
						default: begin qsecs = 13'd60;  qpow = 4'd7;  end
					endcase
					n_running   = 1'b0;
					n_secs      = qsecs;
					d.time_en   = 1'b1;
					d.time_secs = qsecs;
					n_power     = qpow;
					d.power_en  = 1'b1;
					d.power_val = qpow;
					if (!n_door) begin
						d.b_en    = 1'b1;
						d.b_btn   = ackc_pkg::BTN_START;
						d.b_cue   = n_held ? ackc_pkg::CUE_NONE : ackc_pkg::CUE_START;
						n_running = 1'b1;
						n_sp      = 1'b0;
						n_voice   = ackc_pkg::VOICE_SAT;
						n_second  = '0;
						n_held    = 1'b0;
					end else begin
						n_sp = 1'b1;
					end
				end
				5'd10: begin
					if (!n_door) begin
						if (n_secs != '0) begin
							d.b_en    = 1'b1;
							d.b_btn   = ackc_pkg::BTN_START;
							d.b_cue   = n_held ? ackc_pkg::CUE_NONE : ackc_pkg::CUE_START;
							n_running = 1'b1;
							n_sp      = 1'b0;
							n_voice   = ackc_pkg::VOICE_SAT;
							n_second  = '0;
							n_held    = 1'b0;
						end
					end else begin
						n_sp = 1'b1;
					end
				end
				5'd11: begin
					d.b_en    = 1'b1;
					d.b_btn   = ackc_pkg::BTN_STOP;
					d.b_cue   = ackc_pkg::CUE_STOP;
					n_running = 1'b0;
					n_held    = 1'b0;
					n_sp      = 1'b0;
					n_secs    = '0;
					n_power   = '0;
				end
				5'd12, 5'd13, 5'd16, 5'd17: begin
					case (kv)
						5'd12:   extra = 13'd10;
						5'd13:   extra = 13'd600;
						5'd16:   extra = 13'd1;
						default: extra = 13'd60;
					endcase
					sum         = {1'b0, n_secs} + {1'b0, extra};
					n_running   = 1'b0;
					n_secs      = (sum > {1'b0, ackc_pkg::MAX_SECS}) ? extra : sum[12:0];
					d.time_en   = 1'b1;
					d.time_secs = n_secs;
					d.time_cue  = ackc_pkg::CUE_BUTTON;
				end
				5'd14, 5'd15, 5'd18, 5'd19: begin
					case (kv)
						5'd14:   qpow = 4'd7;
						5'd15:   qpow = 4'd3;
						5'd18:   qpow = 4'd10;
						default: qpow = 4'd5;
					endcase
					if (!n_running) begin
						n_power     = qpow;
						d.power_en  = 1'b1;
						d.power_val = qpow;
						d.power_cue = ackc_pkg::CUE_BUTTON;
					end else begin
						d.b_en  = 1'b1;
						d.b_btn = ackc_pkg::BTN_NONE;
						d.b_cue = ackc_pkg::CUE_BUTTON;
					end
				end
				default: ;
			endcase
		end

		d.status.cooking      = n_running;
		d.status.is_paused    = n_held;
		d.status.door_is_open = n_door;
		d.status.time_left    = n_secs;
		d.status.power_level  = n_power;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_s1 <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			held_q        <= 1'b0;
			door_open_q   <= 1'b0;
			start_pend_q  <= 1'b0;
			secs_q        <= '0;
			power_q       <= '0;
			last_key_q    <= ackc_pkg::BTN_NONE;
			release_q     <= '0;
			second_q      <= '0;
			voice_q       <= ackc_pkg::VOICE_SAT;
			desc_valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				running_q    <= n_running;
				held_q       <= n_held;
				door_open_q  <= n_door;
				start_pend_q <= n_sp;
				secs_q       <= n_secs;
				power_q      <= n_power;
				last_key_q   <= n_last;
				release_q    <= n_release;
				second_q     <= n_second;
				voice_q      <= n_voice;
			end
			if (pop) begin
				desc_valid_s1 <= 1'b1;
			end else if (desc_take) begin
				desc_valid_s1 <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/ackc_emit.sv @@
// digit expansion and press sequencer feeding the output register
module ackc_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_valid,
	input  ackc_pkg::desc_t    desc,
	output logic               desc_take,
	output logic               result_valid,
	input  logic               result_stall,
	output ackc_pkg::out_item_t result
);

	function automatic logic [3:0] div10(input logic [6:0] x);
		logic [14:0] p;
		begin
			p = 15'(x) * 15'd205;
			return p[14:11];
		end
	endfunction

	logic            valid_s2;
	ackc_pkg::desc_t desc_s2;
	logic [6:0]      min_s2;
	logic [3:0]      hour_s2;

	logic                    valid_s3;
	logic [ackc_pkg::NSLOT-1:0] mask_s3;
	logic [4:0]              btn_s3 [ackc_pkg::NSLOT];
	logic [2:0]              cue_s3 [ackc_pkg::NSLOT];
	ackc_pkg::status_t       status_s3;
	logic [3:0]              cnt_q;

	logic                    out_valid_q;
	ackc_pkg::out_item_t     out_q;

	logic [27:0] prod_m;
	logic [23:0] prod_h;
	logic        load_s2, load_s3, load_out;
	logic        last;
	logic [ackc_pkg::NSLOT-1:0] pick, rest;
	logic [4:0]  pick_btn;
	logic [2:0]  pick_cue;

	logic [12:0] sec_rem;
	logic [5:0]  sec;
	logic [3:0]  min_hi, min_lo, sec_hi, sec_lo;
	logic [10:0] clk_rem;
	logic [6:0]  mins;
	logic [3:0]  c_tens, c_ones, c_hund;
	logic        clock_ok;
	logic [ackc_pkg::NSLOT-1:0] m_mask;
	logic [4:0]  m_btn [ackc_pkg::NSLOT];
	logic [2:0]  m_cue [ackc_pkg::NSLOT];

	assign prod_m = 28'(desc.time_secs) * 28'd17477;
	assign prod_h = 24'(desc.clock_val) * 24'd5243;

	always_comb begin
		pick     = '0;
		pick_btn = ackc_pkg::BTN_NONE;
		pick_cue = ackc_pkg::CUE_NONE;
		for (int i = ackc_pkg::NSLOT - 1; i >= 0; i--) begin
			if (mask_s3[i]) begin
				pick     = '0;
				pick[i]  = 1'b1;
				pick_btn = btn_s3[i];
				pick_cue = cue_s3[i];
			end
		end
	end

	assign rest      = mask_s3 & ~pick;
	assign last      = (rest == '0) || (cnt_q == 4'd8);
	assign load_out  = valid_s3 && (!out_valid_q || !result_stall);
	assign load_s3   = valid_s2 && (!valid_s3 || (load_out && last));
	assign load_s2   = desc_valid && (!valid_s2 || load_s3);
	assign desc_take = load_s2;

	always_comb begin
		sec_rem = desc_s2.time_secs - 13'(13'(min_s2) * 13'd60);
		sec     = sec_rem[5:0];
		min_hi  = div10(min_s2);
		min_lo  = 4'(min_s2 - 7'(7'(min_hi) * 7'd10));
		sec_hi  = div10({1'b0, sec});
		sec_lo  = 4'(sec - 6'(6'(sec_hi) * 6'd10));
		clk_rem = desc_s2.clock_val - 11'(11'(hour_s2) * 11'd100);
		mins    = clk_rem[6:0];
		c_tens  = div10(mins);
		c_ones  = 4'(mins - 7'(7'(c_tens) * 7'd10));
		c_hund  = (hour_s2 >= 4'd10) ? hour_s2 - 4'd10 : hour_s2;
		clock_ok = desc_s2.clock_en && mins <= 7'd59;

		for (int i = 0; i < ackc_pkg::NSLOT; i++) begin
			m_btn[i] = ackc_pkg::BTN_NONE;
			m_cue[i] = ackc_pkg::CUE_NONE;
		end
		m_btn[0]  = desc_s2.a_btn;
		m_cue[0]  = desc_s2.a_cue;
		m_btn[1]  = ackc_pkg::BTN_TIME;
		m_cue[1]  = desc_s2.time_cue;
		m_btn[2]  = {1'b0, min_hi};
		m_btn[3]  = {1'b0, min_lo};
		m_btn[4]  = {1'b0, sec_hi};
		m_btn[5]  = {1'b0, sec_lo};
		m_btn[6]  = ackc_pkg::BTN_POWER;
		m_cue[6]  = desc_s2.power_cue;
		m_btn[7]  = (desc_s2.power_val == 4'd10) ? 5'd1 : {1'b0, desc_s2.power_val};
		m_btn[8]  = 5'd0;
		m_btn[9]  = ackc_pkg::BTN_CLOCK;
		m_btn[10] = ackc_pkg::BTN_STOP;
		m_btn[11] = 5'd1;
		m_btn[12] = {1'b0, c_hund};
		m_btn[13] = {1'b0, c_tens};
		m_btn[14] = {1'b0, c_ones};
		m_btn[15] = ackc_pkg::BTN_CLOCK;
		m_btn[16] = desc_s2.b_btn;
		m_cue[16] = desc_s2.b_cue;

		m_mask[0]  = desc_s2.a_en;
		m_mask[1]  = desc_s2.time_en;
		m_mask[2]  = desc_s2.time_en && min_s2 >= 7'd10;
		m_mask[3]  = desc_s2.time_en && min_s2 != '0;
		m_mask[4]  = desc_s2.time_en && (sec >= 6'd10 || min_s2 != '0);
		m_mask[5]  = desc_s2.time_en;
		m_mask[6]  = desc_s2.power_en;
		m_mask[7]  = desc_s2.power_en;
		m_mask[8]  = desc_s2.power_en && desc_s2.power_val == 4'd10;
		m_mask[9]  = clock_ok;
		m_mask[10] = clock_ok;
		m_mask[11] = clock_ok && desc_s2.clock_val >= 11'd1000;
		m_mask[12] = clock_ok;
		m_mask[13] = clock_ok;
		m_mask[14] = clock_ok;
		m_mask[15] = clock_ok;
		m_mask[16] = desc_s2.b_en;

		if (m_mask == '0) begin
			m_mask[0] = 1'b1;
			m_btn[0]  = ackc_pkg::BTN_NONE;
			m_cue[0]  = ackc_pkg::CUE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			desc_s2 <= desc;
			min_s2  <= prod_m[26:20];
			hour_s2 <= prod_h[22:19];
		end
		if (load_s3) begin
			btn_s3    <= m_btn;
			cue_s3    <= m_cue;
			status_s3 <= desc_s2.status;
		end
		if (load_out) begin
			out_q.panel_button <= pick_btn;
			out_q.last_result  <= last;
			out_q.sound_cue    <= pick_cue;
			out_q.cooking      <= status_s3.cooking;
			out_q.is_paused    <= status_s3.is_paused;
			out_q.door_is_open <= status_s3.door_is_open;
			out_q.time_left    <= status_s3.time_left;
			out_q.power_level  <= status_s3.power_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			mask_s3     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (load_s3) begin
				valid_s2 <= 1'b0;
			end
			if (load_s3) begin
				valid_s3 <= 1'b1;
				mask_s3  <= m_mask;
				cnt_q    <= '0;
			end else if (load_out) begin
				if (last) begin
					valid_s3 <= 1'b0;
					mask_s3  <= '0;
					cnt_q    <= '0;
				end else begin
					mask_s3 <= rest;
					cnt_q   <= cnt_q + 4'd1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> mask_s3 != '0)
		else $error("sequencer holds an item with no press left");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8)
		else $error("more than nine results for one item");
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !last) |=> valid_s3)
		else $error("item dropped before its last result");

endmodule

@@ sim/tb_appliance_keypad_cook_controller_core.sv @@
// testbench for the cook controller core: random and directed items checked against a predictor
`timescale 1ns / 1ps
module tb_appliance_keypad_cook_controller_core;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	ackc_pkg::in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	ackc_pkg::out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	appliance_keypad_cook_controller_core u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] m_sec_ticks, m_deb_ticks;
	logic [16:0] m_voice_win;
	bit m_run, m_held, m_door_open, m_start_pend;
	int unsigned m_secs, m_power, m_last_key, m_rel_cnt, m_sec_cnt, m_voice_cnt;
	int unsigned cue_hold;
	ackc_pkg::out_item_t step_res[$];

	ackc_pkg::in_item_t pending_items[$];
	ackc_pkg::out_item_t expected_results[$];
	int unsigned errors = 0;
	int unsigned send_idle_pct = 0, stall_pct = 0;
	longint unsigned cycles = 0;

	const int unsigned keymap[6][6] = '{
		'{20, 20, 20, 20, 20, 19},
		'{20, 0, 1, 2, 3, 20},
		'{20, 4, 5, 6, 7, 20},
		'{10, 8, 9, 12, 15, 20},
		'{20, 13, 18, 11, 16, 20},
		'{17, 20, 14, 20, 20, 20}};

	function automatic void put_result(int unsigned btn, int unsigned cue);
		ackc_pkg::out_item_t r;
		if (step_res.size() < 9) begin
			r = '0;
			r.panel_button = btn[4:0];
			r.sound_cue = cue[2:0];
			step_res.push_back(r);
		end
	endfunction

	function automatic void push_key(int unsigned btn);
		put_result(btn, cue_hold);
		cue_hold = 0;
	endfunction

	function automatic void enter_time(int unsigned s);
		int unsigned mm, ss;
		if (s > 5999) return;
		m_run = 0;
		m_secs = s;
		push_key(ackc_pkg::BTN_TIME);
		mm = s / 60;
		ss = s % 60;
		if (mm != 0) begin
			if (mm / 10 != 0) push_key(mm / 10);
			push_key(mm % 10);
		end
		if (ss >= 10 || mm != 0) push_key(ss / 10);
		push_key(ss % 10);
	endfunction

	function automatic void extend_time(int unsigned extra);
		int unsigned b;
		b = m_secs;
		if (b + extra > 5999) b = 0;
		enter_time(b + extra);
	endfunction

	function automatic void enter_power(int unsigned p);
		if (p > 10) return;
		m_power = p;
		push_key(ackc_pkg::BTN_POWER);
		if (p == 10) begin
			push_key(1);
			push_key(0);
		end else begin
			push_key(p);
		end
	endfunction

	function automatic void enter_clock(int unsigned t);
		if (t > 1259 || t < 100 || t % 100 > 59) return;
		push_key(ackc_pkg::BTN_CLOCK);
		push_key(ackc_pkg::BTN_STOP);
		if (t >= 1000) push_key(1);
		push_key(t % 1000 / 100);
		push_key(t % 100 / 10);
		push_key(t % 10);
		push_key(ackc_pkg::BTN_CLOCK);
	endfunction

	function automatic void oven_start();
		if (!m_door_open) begin
			if (m_secs > 0) begin
				put_result(ackc_pkg::BTN_START,
					m_held ? ackc_pkg::CUE_NONE : ackc_pkg::CUE_START);
				m_run = 1;
				m_start_pend = 0;
				m_voice_cnt = ackc_pkg::VOICE_SAT;
				m_sec_cnt = 0;
				m_held = 0;
			end
		end else begin
			m_start_pend = 1;
		end
	endfunction

	function automatic void oven_stop(int unsigned cue);
		put_result(ackc_pkg::BTN_STOP, cue);
		m_run = 0;
		m_held = 0;
		m_start_pend = 0;
		m_secs = 0;
		m_power = 0;
	endfunction

	function automatic void quick_cook(int unsigned s, int unsigned p);
		enter_time(s);
		enter_power(p);
		oven_start();
	endfunction

	function automatic void panel_key(int unsigned k);
		if (k >= 12 && k <= 19) cue_hold = 1;
		case (k)
			0: quick_cook(120, 7);
			1: quick_cook(10, 10);
			2: quick_cook(20, 10);
			3: quick_cook(30, 10);
			4: quick_cook(60, 10);
			5: quick_cook(120, 10);
			6: quick_cook(10, 7);
			7: quick_cook(20, 7);
			8: quick_cook(30, 7);
			9: quick_cook(60, 7);
			10: oven_start();
			11: oven_stop(ackc_pkg::CUE_STOP);
			12: extend_time(10);
			13: extend_time(600);
			14: if (!m_run) enter_power(7);
			15: if (!m_run) enter_power(3);
			16: extend_time(1);
			17: extend_time(60);
			18: if (!m_run) enter_power(10);
			19: if (!m_run) enter_power(5);
			default: ;
		endcase
		if (cue_hold != 0) put_result(ackc_pkg::BTN_NONE, cue_hold);
		cue_hold = 0;
	endfunction

	function automatic void predict_cook(ackc_pkg::in_item_t it);
		int unsigned nxt, k, c;
		bit ok;
		step_res.delete();
		cue_hold = 0;
		if (it.operation == ackc_pkg::OP_TICK) begin
			nxt = m_sec_cnt + 1;
			if (m_rel_cnt < 65535) m_rel_cnt++;
			if (m_voice_cnt < ackc_pkg::VOICE_SAT) m_voice_cnt++;
			if (m_run && nxt > m_sec_ticks) begin
				m_sec_cnt = 0;
				if (m_secs > 0) m_secs--;
				if (m_secs == 0) oven_stop(ackc_pkg::CUE_DONE);
			end else begin
				m_sec_cnt = nxt > 65535 ? 65535 : nxt;
			end
		end else if (it.operation == ackc_pkg::OP_ROW) begin
			if (!it.door_closed) begin
				if (m_run) oven_stop(ackc_pkg::CUE_NONE);
				m_door_open = 1;
			end else if (m_door_open) begin
				m_door_open = 0;
				m_voice_cnt = 0;
				if (m_start_pend) oven_start();
			end
			if (it.column_bits != 0) begin
				k = 20;
				if (it.scan_row < 6)
					for (c = 0; c < 6 && k == 20; c++)
						if (it.column_bits[5 - c]) k = keymap[it.scan_row][c];
				if (k != 20 && k != m_last_key) begin
					panel_key(k);
					m_last_key = k;
				end
				m_rel_cnt = 0;
			end else if (m_last_key != 20 && m_rel_cnt > m_deb_ticks) begin
				m_last_key = 20;
				m_rel_cnt = 0;
			end
		end else if (it.operation == ackc_pkg::OP_HOST) begin
			ok = !it.from_voice || m_voice_cnt < m_voice_win;
			case (it.host_command)
				ackc_pkg::HC_RAW: if (it.host_value < 20) push_key(it.host_value);
				ackc_pkg::HC_TIME: if (ok) enter_time(it.host_value);
				ackc_pkg::HC_POWER: if (ok) enter_power(it.host_value);
				ackc_pkg::HC_START: if (ok) oven_start();
				ackc_pkg::HC_STOP: if (ok) oven_stop(ackc_pkg::CUE_NONE);
				ackc_pkg::HC_PAUSE: if (m_run) begin
					push_key(ackc_pkg::BTN_TIME);
					m_run = 0;
					m_held = 1;
				end
				ackc_pkg::HC_CLOCK: enter_clock(it.host_value);
				default: if (it.host_value < 20) panel_key(it.host_value);
			endcase
		end
		if (step_res.size() == 0) put_result(ackc_pkg::BTN_NONE, ackc_pkg::CUE_NONE);
		foreach (step_res[i]) begin
			step_res[i].last_result = (i == step_res.size() - 1);
			step_res[i].cooking = m_run;
			step_res[i].is_paused = m_held;
			step_res[i].door_is_open = m_door_open;
			step_res[i].time_left = m_secs[12:0];
			step_res[i].power_level = m_power[3:0];
			expected_results.push_back(step_res[i]);
		end
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		cycles++;
		if (!item_valid || !item_stall) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= pending_items[0];
				predict_cook(pending_items.pop_front());
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		ackc_pkg::out_item_t w;
		if (result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result button", result.panel_button, 0);
			end else begin
				w = expected_results.pop_front();
				if (result.panel_button !== w.panel_button)
					report_mismatch("panel_button", result.panel_button, w.panel_button);
				if (result.last_result !== w.last_result)
					report_mismatch("last_result", result.last_result, w.last_result);
				if (result.sound_cue !== w.sound_cue)
					report_mismatch("sound_cue", result.sound_cue, w.sound_cue);
				if (result.cooking !== w.cooking)
					report_mismatch("cooking", result.cooking, w.cooking);
				if (result.is_paused !== w.is_paused)
					report_mismatch("is_paused", result.is_paused, w.is_paused);
				if (result.door_is_open !== w.door_is_open)
					report_mismatch("door_is_open", result.door_is_open, w.door_is_open);
				if (result.time_left !== w.time_left)
					report_mismatch("time_left", result.time_left, w.time_left);
				if (result.power_level !== w.power_level)
					report_mismatch("power_level", result.power_level, w.power_level);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("appliance_keypad_cook_controller_core verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ackc_pkg::REG_SECOND: m_sec_ticks = val[15:0];
			ackc_pkg::REG_DEBOUNCE: m_deb_ticks = val[15:0];
			default: m_voice_win = val[16:0];
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic ackc_pkg::in_item_t mk_item(logic [1:0] op, int unsigned row,
			int unsigned cols, bit closed, logic [2:0] cmd, int unsigned val, bit voice);
		ackc_pkg::in_item_t it;
		it.operation = op;
		it.scan_row = row[2:0];
		it.column_bits = cols[5:0];
		it.door_closed = closed;
		it.host_command = cmd;
		it.host_value = val[12:0];
		it.from_voice = voice;
		return it;
	endfunction

	function automatic ackc_pkg::in_item_t rand_item();
		ackc_pkg::in_item_t it;
		int unsigned r, v;
		it = ackc_pkg::in_item_t'($bits(ackc_pkg::in_item_t)'($urandom));
		r = $urandom_range(99);
		if (r < 45) begin
			it.operation = ackc_pkg::OP_TICK;
		end else if (r < 70) begin
			it.operation = ackc_pkg::OP_ROW;
			if ($urandom_range(3) == 0) it.column_bits = 0;
			it.door_closed = ($urandom_range(7) != 0);
		end else if (r < 98) begin
			it.operation = ackc_pkg::OP_HOST;
			case ($urandom_range(4))
				0: v = $urandom_range(5999);
				1: v = $urandom_range(11);
				2: v = $urandom_range(1300);
				3: v = $urandom_range(21);
				default: v = $urandom_range(8191);
			endcase
			it.host_value = v[12:0];
		end else begin
			it.operation = 2'd3;
		end
		return it;
	endfunction

	initial begin
		m_sec_ticks = 1000;
		m_deb_ticks = 100;
		m_voice_win = 10000;
		m_run = 0; m_held = 0; m_door_open = 0; m_start_pend = 0;
		m_secs = 0; m_power = 0; m_last_key = 20;
		m_rel_cnt = 0; m_sec_cnt = 0; m_voice_cnt = ackc_pkg::VOICE_SAT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(ackc_pkg::REG_SECOND, 3);
		write_reg(ackc_pkg::REG_DEBOUNCE, 2);
		write_reg(ackc_pkg::REG_VOICE, 40);
		// directed part
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_TIME, 5999, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_TIME, 6000, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_POWER, 10, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_POWER, 11, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_CLOCK, 1259, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_CLOCK, 960, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_RAW, 19, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_RAW, 8191, 1));
		pending_items.push_back(mk_item(ackc_pkg::OP_ROW, 0, 0, 0, ackc_pkg::HC_RAW, 0, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_TIME, 5, 1));
		pending_items.push_back(mk_item(ackc_pkg::OP_ROW, 0, 0, 1, ackc_pkg::HC_RAW, 0, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_TIME, 3, 1));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_START, 0, 1));
		pending_items.push_back(mk_item(ackc_pkg::OP_ROW, 3, 6'h3F, 1, ackc_pkg::HC_RAW, 0, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_PAUSE, 0, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_KEY, 10, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_HOST, 0, 0, 1, ackc_pkg::HC_KEY, 18, 0));
		pending_items.push_back(mk_item(ackc_pkg::OP_ROW, 7, 6'h3F, 1, ackc_pkg::HC_RAW, 0, 0));
		for (int i = 0; i < 20; i++)
			pending_items.push_back(mk_item(ackc_pkg::OP_TICK, 0, 0, 1, ackc_pkg::HC_RAW, 0, 0));
		pending_items.push_back(mk_item(2'd3, 7, 6'h3F, 1, ackc_pkg::HC_KEY, 8191, 1));
		drain();
		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 75; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 75; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			case (ph)
				0: begin write_reg(ackc_pkg::REG_SECOND, 1);
					write_reg(ackc_pkg::REG_DEBOUNCE, 1);
					write_reg(ackc_pkg::REG_VOICE, 1); end
				1: begin write_reg(ackc_pkg::REG_SECOND, 5);
					write_reg(ackc_pkg::REG_DEBOUNCE, 65535);
					write_reg(ackc_pkg::REG_VOICE, 131071); end
				2: begin write_reg(ackc_pkg::REG_SECOND, 2);
					write_reg(ackc_pkg::REG_DEBOUNCE, 3);
					write_reg(ackc_pkg::REG_VOICE, 20); end
				default: begin write_reg(ackc_pkg::REG_SECOND, 65535);
					write_reg(ackc_pkg::REG_DEBOUNCE, 4);
					write_reg(ackc_pkg::REG_VOICE, 8); end
			endcase
			for (int i = 0; i < 48; i++) pending_items.push_back(rand_item());
			drain();
		end
		if (errors == 0)
			$display("appliance_keypad_cook_controller_core verification clean");
		else
			$display("appliance_keypad_cook_controller_core verification failed");
		$finish;
	end
endmodule
